FILE: hdl/chse_pkg.sv
`default_nettype none

package chse_pkg;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int T_W        = 17;
    localparam int TT_W       = 33;
    localparam int T3_W       = 49;
    localparam int RAW_W      = 51;
    localparam int WGT_W      = 31;
    localparam int NEG_W      = 33;
    localparam int ACC_W      = 64;
    localparam int Q_W        = 34;
    localparam int IN_TDATA_W = 152;
    localparam int OUT_TDATA_W = 32;

    // Fixed-point constants
    localparam logic [T_W-1:0]   ONE_Q16   = 17'd65536;
    localparam logic [RAW_W-1:0] ONE_Q48   = 51'd1 << 48;
    localparam logic [RAW_W-1:0] WGT_HALF  = 51'd1 << 17;
    localparam logic [ACC_W-1:0] OUT_HALF  = 64'd1 << 29;

    // Coordinates carried along the weight stages
    typedef struct packed {
        logic signed [COORD_W-1:0] p0;
        logic signed [COORD_W-1:0] p1;
        logic signed [COORD_W-1:0] m0;
        logic signed [COORD_W-1:0] m1;
    } t_coords;

    // Weights and operands handed to the multiply-accumulate stages
    typedef struct packed {
        logic [WGT_W-1:0]          w00;
        logic [WGT_W-1:0]          w01;
        logic [WGT_W-1:0]          w10;
        logic [WGT_W-1:0]          w11_mag;
        logic signed [COORD_W-1:0] p0;
        logic signed [COORD_W-1:0] p1;
        logic signed [COORD_W-1:0] m0;
        logic signed [NEG_W-1:0]   neg_m1;
    } t_wgt_item;

    // Round a Q.48 weight to Q.30, ties up
    function automatic logic [WGT_W-1:0] round_weight(input logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0] sum;
        sum = raw + WGT_HALF;
        return sum[48:18];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cubic_hermite_spline_eval_unit.sv
// Cubic Hermite curve evaluator, one coordinate per transfer.
// Input stream (s_axis): one transfer carries p0, p1, m0, m1 (signed Q16.16)
// and t (unsigned Q1.16, 65536 = 1.0; larger values act as 1.0).
// Output stream (m_axis): one transfer per input transfer, in order, with
// the interpolated coordinate in tdata and a clip flag in tuser.
// A 3D point is sent as three consecutive transfers, one per axis.
// Throughput: one transfer per cycle while m_axis_tready is high; the
// pipeline has seven register stages (clamp and square, cube, weight
// rounding, four multiplies, pair sums, total, round and clamp into the
// output register).
// Stall: when m_axis_tready is low the result holds in the output register
// and the stall travels back stage by stage; empty stages keep filling, so
// s_axis_tready drops only once the pipeline is full.
// Reset (i_rst_n low, synchronous) clears all valid bits; no result is
// presented after reset until a new input transfer arrives.
`default_nettype none

module cubic_hermite_spline_eval_unit
    import chse_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] start_point, [63:32] end_point, [95:64] start_slope,
    // [127:96] end_slope, [144:128] param_t, [151:145] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] curve_value
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] saturated
    output logic                        m_axis_tuser
);

    t_coords          in_coords;
    logic [T_W-1:0]   in_t;
    t_wgt_item        wgt_item;
    logic             wgt_valid, wgt_ready;
    logic signed [ACC_W-1:0] acc;
    logic             acc_valid, acc_ready;

    // Unpack the input transfer
    always_comb begin
        in_coords.p0 = s_axis_tdata[31:0];
        in_coords.p1 = s_axis_tdata[63:32];
        in_coords.m0 = s_axis_tdata[95:64];
        in_coords.m1 = s_axis_tdata[127:96];
        in_t         = s_axis_tdata[144:128];
    end

    chse_weights u_weights (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_coords (in_coords),
        .i_t      (in_t),
        .o_valid  (wgt_valid),
        .i_ready  (wgt_ready),
        .o_item   (wgt_item)
    );

    chse_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wgt_valid),
        .o_ready (wgt_ready),
        .i_item  (wgt_item),
        .o_valid (acc_valid),
        .i_ready (acc_ready),
        .o_acc   (acc)
    );

    chse_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc_valid),
        .o_ready (acc_ready),
        .i_acc   (acc),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (m_axis_tdata),
        .o_sat   (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: hdl/chse_weights.sv
`default_nettype none

module chse_weights
    import chse_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_coords          i_coords,
    input  wire logic [T_W-1:0]   i_t,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_wgt_item             o_item
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    t_coords          r_s1_c, r_s2_c;
    logic [T_W-1:0]   r_s1_t, r_s2_t;
    logic [TT_W-1:0]  r_s1_tt, r_s2_tt;
    logic [T3_W-1:0]  r_s2_t3;
    t_wgt_item        r_s3_item;

    logic [T_W-1:0]   n_t;
    logic [TT_W-1:0]  n_tt;
    logic [T3_W-1:0]  n_t3;
    logic [RAW_W-1:0] a3, s2, tl, raw00, raw01, raw10, raw11;
    t_wgt_item        n_item;

    // Stall chain: a stage loads when empty or when its successor moves
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_item  = r_s3_item;

    // Stage 1: clamp t to one and square it
    always_comb begin
        n_t  = (i_t > ONE_Q16) ? ONE_Q16 : i_t;
        n_tt = TT_W'(n_t * n_t);
    end

    // Stage 2: cube
    always_comb begin
        n_t3 = T3_W'(r_s1_tt * r_s1_t);
    end

    // Stage 3: form the four Q.48 weights and round them to Q.30
    always_comb begin
        a3 = {2'b00, r_s2_t3};
        s2 = {2'b00, r_s2_tt, 16'd0};
        tl = {2'b00, r_s2_t, 32'd0};
        raw00 = (a3 << 1) + ONE_Q48 - (s2 + (s2 << 1));
        raw01 = (s2 + (s2 << 1)) - (a3 << 1);
        raw10 = a3 + tl - (s2 << 1);
        raw11 = s2 - a3;
        n_item.w00     = round_weight(raw00);
        n_item.w01     = round_weight(raw01);
        n_item.w10     = round_weight(raw10);
        n_item.w11_mag = round_weight(raw11);
        n_item.p0      = r_s2_c.p0;
        n_item.p1      = r_s2_c.p1;
        n_item.m0      = r_s2_c.m0;
        n_item.neg_m1  = -NEG_W'(r_s2_c.m1);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_c  <= i_coords;
            r_s1_t  <= n_t;
            r_s1_tt <= n_tt;
        end
        if (rdy2 && r_v1) begin
            r_s2_c  <= r_s1_c;
            r_s2_t  <= r_s1_t;
            r_s2_tt <= r_s1_tt;
            r_s2_t3 <= n_t3;
        end
        if (rdy3 && r_v2) begin
            r_s3_item <= n_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/chse_mac.sv
`default_nettype none

module chse_mac
    import chse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_wgt_item         i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [ACC_W-1:0] o_acc
);

    logic r_v4, r_v5, r_v6;
    logic rdy4, rdy5, rdy6;

    logic signed [ACC_W-1:0] r_s4_prod0, r_s4_prod1, r_s4_prod2, r_s4_prod3;
    logic signed [ACC_W-1:0] r_s5_sum01, r_s5_sum23;
    logic signed [ACC_W-1:0] r_s6_acc;

    logic signed [COORD_W-1:0] w00_s, w01_s, w10_s, w11_s;
    logic signed [ACC_W-1:0]   n_prod0, n_prod1, n_prod2, n_prod3;

    // Stall chain
    assign rdy6    = !r_v6 || i_ready;
    assign rdy5    = !r_v5 || rdy6;
    assign rdy4    = !r_v4 || rdy5;
    assign o_ready = rdy4;
    assign o_valid = r_v6;
    assign o_acc   = r_s6_acc;

    // Stage 4: weight times coordinate, last term uses the negated end slope
    always_comb begin
        w00_s   = {1'b0, i_item.w00};
        w01_s   = {1'b0, i_item.w01};
        w10_s   = {1'b0, i_item.w10};
        w11_s   = {1'b0, i_item.w11_mag};
        n_prod0 = w00_s * i_item.p0;
        n_prod1 = w01_s * i_item.p1;
        n_prod2 = w10_s * i_item.m0;
        n_prod3 = w11_s * i_item.neg_m1;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (rdy4) r_v4 <= i_valid;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
        end
    end

    // Products, pair sums, then the Q.46 total
    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r_s4_prod0 <= n_prod0;
            r_s4_prod1 <= n_prod1;
            r_s4_prod2 <= n_prod2;
            r_s4_prod3 <= n_prod3;
        end
        if (rdy5 && r_v4) begin
            r_s5_sum01 <= r_s4_prod0 + r_s4_prod1;
            r_s5_sum23 <= r_s4_prod2 + r_s4_prod3;
        end
        if (rdy6 && r_v5) begin
            r_s6_acc <= r_s5_sum01 + r_s5_sum23;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/chse_sat.sv
`default_nettype none

module chse_sat
    import chse_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [ACC_W-1:0] i_acc,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [COORD_W-1:0]           o_value,
    output logic                         o_sat
);

    logic r_v7;
    logic rdy7;
    logic [COORD_W-1:0] r_s7_value;
    logic               r_s7_sat;

    logic [ACC_W-1:0]   rnd;
    logic [Q_W-1:0]     q;
    logic               n_sat;
    logic [COORD_W-1:0] n_value;

    assign rdy7    = !r_v7 || i_ready;
    assign o_ready = rdy7;
    assign o_valid = r_v7;
    assign o_value = r_s7_value;
    assign o_sat   = r_s7_sat;

    // Round Q.46 to Q16.16 (floor after adding half) and clamp to 32 bits
    always_comb begin
        rnd   = i_acc + OUT_HALF;
        q     = rnd[ACC_W-1:30];
        n_sat = !((q[Q_W-1:31] == 3'b000) || (q[Q_W-1:31] == 3'b111));
        if (!n_sat) begin
            n_value = q[COORD_W-1:0];
        end else if (q[Q_W-1]) begin
            n_value = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (rdy7) begin
            r_v7 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy7 && i_valid) begin
            r_s7_value <= n_value;
            r_s7_sat   <= n_sat;
        end
    end

endmodule

`default_nettype wire
